[rtl/lse_pkg.sv]
// shared types and constants for the execute unit
package lse_pkg;

  localparam int unsigned MainWordsDef  = 512;
  localparam int unsigned StackWordsDef = 64;
  localparam int unsigned RegCount      = 32;
  localparam logic [4:0]  LinkReg       = 5'd30;
  localparam logic [4:0]  StackBaseReg  = 5'd28;
  localparam logic [4:0]  FrameBoundReg = 5'd29;
  localparam int unsigned WordBytesLog2 = 3;
  localparam int unsigned CondCount     = 14;

  typedef enum logic [4:0] {
    A_ADDI  = 5'd0,  A_ANDI = 5'd1,  A_EORI = 5'd2,  A_ORRI = 5'd3,
    A_SUBI  = 5'd4,  A_SUBIS = 5'd5, A_ADD  = 5'd6,  A_AND  = 5'd7,
    A_BR    = 5'd8,  A_EOR  = 5'd9,  A_LSL  = 5'd10, A_LSR  = 5'd11,
    A_MUL   = 5'd12, A_ORR  = 5'd13, A_SUB  = 5'd14, A_SUBS = 5'd15,
    A_UDIV  = 5'd16, A_B    = 5'd17, A_BL   = 5'd18, A_BCOND = 5'd19,
    A_CBNZ  = 5'd20, A_CBZ  = 5'd21, A_LDUR = 5'd22, A_STUR = 5'd23,
    A_HALT  = 5'd24, A_NOP  = 5'd25
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_AB, S_RD_DB, S_RD_L, S_EXEC, S_MUL, S_DIV, S_WB
  } state_t;

  typedef enum logic [1:0] {
    RD_AB, RD_DB, RD_L
  } rd_phase_t;

  typedef struct packed {
    logic      clr;
    logic      latch;
    rd_phase_t rd_phase;
    logic      cap_ab;
    logic      cap_db;
    logic      exec;
    logic      mul_step;
    logic      div_step;
    logic      wb;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_mul;
    logic is_div;
    logic mul_done;
    logic div_done;
  } status_t;

endpackage

[rtl/legv8_subset_execute_unit.sv]
// top level of the legv8 subset execute unit
// usage
//   one decoded instruction is a beat on the in_ ports, accepted at a clock
//   edge where start is high and busy is low
//   each result beat stands on the out_ ports for one cycle, flagged by
//   out_valid; the receiver has no way to hold it off
// sequencing
//   register file reads run in states RD_AB, RD_DB and RD_L (two read ports,
//   five operands), then an execute state and a write-back state; out_valid
//   is registered from write-back and busy drops in that same cycle
//   mul adds the S_MUL state (one 32x32 partial product per cycle)
//   udiv adds the S_DIV state (restoring divider, one quotient bit per cycle)
//   one instruction is in flight at a time
// reset
//   synchronous, active low; after reset a clearing pass zeroes register
//   file, main store and stack store, one word of each per cycle, while
//   its counter runs up to max(MAIN_WORDS, STACK_WORDS, 32) - 1, with busy high
//   MAIN_WORDS and STACK_WORDS must be powers of two
module legv8_subset_execute_unit
  import lse_pkg::*;
#(
  parameter int unsigned MAIN_WORDS  = MainWordsDef,
  parameter int unsigned STACK_WORDS = StackWordsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         in_action,
  input  logic [4:0]         in_dest_reg,
  input  logic [4:0]         in_src_reg,
  input  logic [4:0]         in_second_reg,
  input  logic signed [25:0] in_imm,
  input  logic [5:0]         in_shift_amount,
  input  logic [3:0]         in_condition,
  output logic               out_valid,
  output logic [15:0]        out_next_pc,
  output logic               out_halted,
  output logic               out_write_enable,
  output logic signed [63:0] out_written_value,
  output logic               out_stack_fault
);

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  lse_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lse_dp #(
    .MAIN_WORDS  (MAIN_WORDS),
    .STACK_WORDS (STACK_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_action         (in_action),
    .in_dest_reg       (in_dest_reg),
    .in_src_reg        (in_src_reg),
    .in_second_reg     (in_second_reg),
    .in_imm            (in_imm),
    .in_shift_amount   (in_shift_amount),
    .in_condition      (in_condition),
    .out_valid         (out_valid),
    .out_next_pc       (out_next_pc),
    .out_halted        (out_halted),
    .out_write_enable  (out_write_enable),
    .out_written_value (out_written_value),
    .out_stack_fault   (out_stack_fault)
  );

`ifndef ASSERT_OFF
  // a result beat is never held over on out_valid
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  // an accepted beat makes the unit busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  // halt writes no register
  a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_halted) |-> !out_write_enable) else $error("halt wrote");
  // a stack fault skips the register write
  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stack_fault) |-> !out_write_enable) else $error("fault wrote");
`endif

endmodule

[rtl/lse_ctrl.sv]
// sequencing state machine for the execute unit
module lse_ctrl
  import lse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_phase = RD_AB;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_RD_AB;
        end
      end
      S_RD_AB: begin
        state_nxt = S_RD_DB;
      end
      S_RD_DB: begin
        cmd.rd_phase = RD_DB;
        cmd.cap_ab   = 1'b1;
        state_nxt    = S_RD_L;
      end
      S_RD_L: begin
        cmd.rd_phase = RD_L;
        cmd.cap_db   = 1'b1;
        state_nxt    = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.is_mul)      state_nxt = S_MUL;
        else if (status.is_div) state_nxt = S_DIV;
        else                    state_nxt = S_WB;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_done) state_nxt = S_WB;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/lse_dp.sv]
// register file, memories, alu, multiply and divide units of the execute unit
module lse_dp
  import lse_pkg::*;
#(
  parameter int unsigned MAIN_WORDS  = MainWordsDef,
  parameter int unsigned STACK_WORDS = StackWordsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [4:0]         in_action,
  input  logic [4:0]         in_dest_reg,
  input  logic [4:0]         in_src_reg,
  input  logic [4:0]         in_second_reg,
  input  logic signed [25:0] in_imm,
  input  logic [5:0]         in_shift_amount,
  input  logic [3:0]         in_condition,
  output logic               out_valid,
  output logic [15:0]        out_next_pc,
  output logic               out_halted,
  output logic               out_write_enable,
  output logic signed [63:0] out_written_value,
  output logic               out_stack_fault
);

  // word counts must be powers of two, unchecked; index slices the word address
  localparam int unsigned MainAw  = $clog2(MAIN_WORDS);
  localparam int unsigned StackAw = $clog2(STACK_WORDS);
  localparam int unsigned RegAw   = $clog2(RegCount);
  localparam int unsigned ClrWords0 = (MAIN_WORDS > STACK_WORDS) ? MAIN_WORDS : STACK_WORDS;
  localparam int unsigned ClrWords  = (ClrWords0 > RegCount) ? ClrWords0 : RegCount;
  localparam int unsigned ClrAw     = $clog2(ClrWords);
  localparam logic [ClrAw-1:0] ClrLast = ClrAw'(ClrWords - 1);

  logic [63:0] rf        [RegCount];
  logic [63:0] main_mem  [MAIN_WORDS];
  logic [63:0] stack_mem [STACK_WORDS];

  logic [ClrAw-1:0] clr_cnt_r;
  logic [4:0]  act_r, rd_r, rn_r, rm_r;
  logic [25:0] imm_r;
  logic [5:0]  sh_r;
  logic [3:0]  cond_r;
  logic [63:0] qa_r, qb_r;
  logic [63:0] a_r, b_r, d_r, bound_r, link_r;
  logic [63:0] val_r, main_q_r, stack_q_r;
  logic        we_r, taken_r, use_stack_r, fault_r;
  logic [15:0] pc_r;
  logic [13:0] flags_r;
  logic [63:0] acc_r, prod_r;
  logic        psh_r;
  logic [1:0]  mcnt_r;
  logic [63:0] quot_r, rem_r;
  logic [5:0]  dcnt_r;
  logic        out_valid_r, out_halted_r, out_we_r, out_fault_r;
  logic [15:0] out_pc_r;
  logic [63:0] out_val_r;

  logic [4:0]  ra, rb;
  logic [63:0] imm64, addr, opb, diff, wb_val, mpart;
  logic        stack_ok, c_f, z_f, n_f, v_f, hi_f, ge_f, gt_f;
  logic [15:0] flags16, pc_nxt;
  logic [64:0] rem_sh, rem_sub;
  logic [4:0]  wa;

  assign imm64 = {{38{imm_r[25]}}, imm_r};
  assign addr  = a_r + imm64;
  assign stack_ok = ($signed(addr) <= $signed(bound_r));

  // register file read ports
  always_comb begin
    case (cmd.rd_phase)
      RD_AB: begin ra = rn_r; rb = rm_r; end
      RD_DB: begin ra = rd_r; rb = FrameBoundReg; end
      RD_L:  begin ra = LinkReg; rb = LinkReg; end
      default: begin ra = rn_r; rb = rm_r; end
    endcase
  end

  // subtract flags
  assign opb  = (act_r == A_SUBI || act_r == A_SUBIS) ? imm64 : b_r;
  assign diff = a_r - opb;
  assign n_f  = diff[63];
  assign z_f  = (diff == '0);
  assign c_f  = (a_r >= opb);
  assign v_f  = ((a_r[63] ^ opb[63]) & (a_r[63] ^ diff[63]));
  assign hi_f = c_f & ~z_f;
  assign ge_f = (n_f == v_f);
  assign gt_f = ~z_f & ge_f;
  assign flags16 = {2'b00, flags_r};

  // multiply partial product, one 32x32 a step
  always_comb begin
    case (mcnt_r)
      2'd0:    mpart = a_r[31:0]  * b_r[31:0];
      2'd1:    mpart = a_r[31:0]  * b_r[63:32];
      2'd2:    mpart = a_r[63:32] * b_r[31:0];
      default: mpart = '0;
    endcase
  end

  // restoring divide, one quotient bit a step
  assign rem_sh  = {rem_r, quot_r[63]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  assign status.clr_done = (clr_cnt_r == ClrLast);
  assign status.is_mul   = (act_r == A_MUL);
  assign status.is_div   = (act_r == A_UDIV);
  assign status.mul_done = (mcnt_r == 2'd3);
  assign status.div_done = (dcnt_r == 6'd63);

  // final write-back value and next pc
  always_comb begin
    case (act_r)
      A_MUL:   wb_val = acc_r;
      A_UDIV:  wb_val = (b_r == '0) ? '0 : quot_r;
      A_LDUR:  wb_val = use_stack_r ? stack_q_r : main_q_r;
      default: wb_val = val_r;
    endcase
    wa = (act_r == A_BL) ? LinkReg : rd_r;
    case (act_r)
      A_BR:    pc_nxt = link_r[15:0] + 16'd1;
      A_HALT:  pc_nxt = pc_r;
      default: pc_nxt = taken_r ? (pc_r + imm_r[15:0]) : (pc_r + 16'd1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.exec && (act_r == A_SUBIS || act_r == A_SUBS)) begin
        flags_r <= {~gt_f, gt_f, ~ge_f, ge_f, ~hi_f, hi_f, ~v_f, v_f,
                    ~n_f, n_f, ~c_f, c_f, ~z_f, z_f};
      end
      if (cmd.wb) pc_r <= pc_nxt;
      out_valid_r <= cmd.wb;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    qa_r <= rf[ra];
    qb_r <= rf[rb];
    if (cmd.clr) begin
      rf[clr_cnt_r[RegAw-1:0]] <= '0;
    end else if (cmd.wb && we_r) begin
      rf[wa] <= wb_val;
    end
  end

  // main and stack stores
  always_ff @(posedge clk) begin
    main_q_r  <= main_mem[addr[WordBytesLog2 +: MainAw]];
    stack_q_r <= stack_mem[addr[WordBytesLog2 +: StackAw]];
    if (cmd.clr) begin
      main_mem[clr_cnt_r[MainAw-1:0]]   <= '0;
      stack_mem[clr_cnt_r[StackAw-1:0]] <= '0;
    end else if (cmd.exec && act_r == A_STUR) begin
      if (rn_r != StackBaseReg) begin
        main_mem[addr[WordBytesLog2 +: MainAw]] <= d_r;
      end else if (stack_ok) begin
        stack_mem[addr[WordBytesLog2 +: StackAw]] <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      rd_r   <= in_dest_reg;
      rn_r   <= in_src_reg;
      rm_r   <= in_second_reg;
      imm_r  <= in_imm;
      sh_r   <= in_shift_amount;
      cond_r <= in_condition;
    end
    if (cmd.cap_ab) begin
      a_r <= qa_r;
      b_r <= qb_r;
    end
    if (cmd.cap_db) begin
      d_r     <= qa_r;
      bound_r <= qb_r;
    end
    if (cmd.exec) begin
      link_r      <= qa_r;
      use_stack_r <= (rn_r == StackBaseReg);
      fault_r     <= (act_r == A_LDUR || act_r == A_STUR) &&
                     (rn_r == StackBaseReg) && !stack_ok;
      acc_r  <= '0;
      prod_r <= '0;
      psh_r  <= 1'b0;
      mcnt_r <= '0;
      quot_r <= a_r;
      rem_r  <= '0;
      dcnt_r <= '0;
      val_r   <= '0;
      we_r    <= 1'b1;
      taken_r <= 1'b0;
      case (act_r)
        A_ADDI:  val_r <= a_r + imm64;
        A_ANDI:  val_r <= a_r & imm64;
        A_EORI:  val_r <= a_r ^ imm64;
        A_ORRI:  val_r <= a_r | imm64;
        A_SUBI, A_SUBIS, A_SUB, A_SUBS: val_r <= diff;
        A_ADD:   val_r <= a_r + b_r;
        A_AND:   val_r <= a_r & b_r;
        A_EOR:   val_r <= a_r ^ b_r;
        A_ORR:   val_r <= a_r | b_r;
        A_LSL:   val_r <= a_r << sh_r;
        A_LSR:   val_r <= a_r >> sh_r;
        A_MUL, A_UDIV: val_r <= '0;
        A_BL: begin
          val_r   <= {48'd0, pc_r};
          taken_r <= 1'b1;
        end
        A_B: begin
          we_r    <= 1'b0;
          taken_r <= 1'b1;
        end
        A_BCOND: begin
          we_r    <= 1'b0;
          taken_r <= flags16[cond_r];
        end
        A_CBNZ: begin
          we_r    <= 1'b0;
          taken_r <= (d_r != '0);
        end
        A_CBZ: begin
          we_r    <= 1'b0;
          taken_r <= (d_r == '0);
        end
        A_LDUR:  we_r <= (rn_r != StackBaseReg) || stack_ok;
        default: we_r <= 1'b0;
      endcase
    end
    if (cmd.mul_step) begin
      acc_r  <= acc_r + (psh_r ? {prod_r[31:0], 32'd0} : prod_r);
      prod_r <= mpart;
      psh_r  <= (mcnt_r != 2'd0);
      mcnt_r <= mcnt_r + 2'd1;
    end
    if (cmd.div_step) begin
      if (!rem_sub[64]) begin
        rem_r  <= rem_sub[63:0];
        quot_r <= {quot_r[62:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[63:0];
        quot_r <= {quot_r[62:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.wb) begin
      out_pc_r     <= pc_nxt;
      out_halted_r <= (act_r == A_HALT);
      out_we_r     <= we_r;
      out_val_r    <= we_r ? wb_val : '0;
      out_fault_r  <= fault_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_pc_r;
  assign out_halted        = out_halted_r;
  assign out_write_enable  = out_we_r;
  assign out_written_value = out_val_r;
  assign out_stack_fault   = out_fault_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the legv8 subset execute unit
module tb
  import lse_pkg::*;
;

  localparam int unsigned MainWords  = 512;
  localparam int unsigned StackWords = 64;
  localparam int unsigned IdleLimit  = 20000;

  // condition codes
  localparam logic [3:0] C_EQ = 4'd0, C_NE = 4'd1, C_HS = 4'd2, C_LO = 4'd3;
  localparam logic [3:0] C_MI = 4'd4, C_PL = 4'd5, C_VS = 4'd6, C_VC = 4'd7;
  localparam logic [3:0] C_HI = 4'd8, C_LS = 4'd9, C_GE = 4'd10, C_LT = 4'd11;
  localparam logic [3:0] C_GT = 4'd12, C_LE = 4'd13;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [4:0] in_action = '0;
  logic [4:0] in_dest_reg = '0;
  logic [4:0] in_src_reg = '0;
  logic [4:0] in_second_reg = '0;
  logic signed [25:0] in_imm = '0;
  logic [5:0] in_shift_amount = '0;
  logic [3:0] in_condition = '0;
  logic out_valid;
  logic [15:0] out_next_pc;
  logic out_halted;
  logic out_write_enable;
  logic signed [63:0] out_written_value;
  logic out_stack_fault;

  // one expected retirement
  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        write_enable;
    logic [63:0] written_value;
    logic        stack_fault;
  } retire_t;

  // architectural shadow state
  logic [63:0] shadow_regs [32];
  logic [63:0] shadow_main [MainWords];
  logic [63:0] shadow_stack [StackWords];
  logic [15:0] shadow_pc;
  logic [13:0] shadow_flags;

  retire_t pending_retires [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  legv8_subset_execute_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_dest_reg(in_dest_reg), .in_src_reg(in_src_reg),
    .in_second_reg(in_second_reg), .in_imm(in_imm),
    .in_shift_amount(in_shift_amount), .in_condition(in_condition),
    .out_valid(out_valid), .out_next_pc(out_next_pc), .out_halted(out_halted),
    .out_write_enable(out_write_enable), .out_written_value(out_written_value),
    .out_stack_fault(out_stack_fault)
  );

  // flags from a subtract, all fourteen conditions at once
  function automatic logic [13:0] sub_flags(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    logic n, z, c, v, hi, ge, gt;
    r = a - b;
    n = r[63];
    z = (r == 64'd0);
    c = (a >= b);
    v = (a[63] ^ b[63]) & (a[63] ^ r[63]);
    hi = c & ~z;
    ge = (n == v);
    gt = ~z & ge;
    return {~gt, gt, ~ge, ge, ~hi, hi, ~v, v, ~n, n, ~c, c, ~z, z};
  endfunction

  // execute one instruction on the shadow state
  function automatic retire_t execute_instr(logic [4:0] act, logic [4:0] rd,
      logic [4:0] rn, logic [4:0] rm, logic [25:0] imm26, logic [5:0] sh,
      logic [3:0] cond);
    logic [63:0] a, b, imm, val, addr;
    logic [15:0] nxt;
    logic we, halt, fault;
    retire_t r;
    imm = {{38{imm26[25]}}, imm26};
    a = shadow_regs[rn];
    b = shadow_regs[rm];
    addr = a + imm;
    val = '0; we = 1'b0; halt = 1'b0; fault = 1'b0;
    nxt = shadow_pc + 16'd1;
    case (act)
      A_ADDI: begin val = a + imm; we = 1'b1; end
      A_ANDI: begin val = a & imm; we = 1'b1; end
      A_EORI: begin val = a ^ imm; we = 1'b1; end
      A_ORRI: begin val = a | imm; we = 1'b1; end
      A_SUBI: begin val = a - imm; we = 1'b1; end
      A_SUBIS: begin val = a - imm; shadow_flags = sub_flags(a, imm); we = 1'b1; end
      A_ADD: begin val = a + b; we = 1'b1; end
      A_AND: begin val = a & b; we = 1'b1; end
      A_BR: nxt = shadow_regs[LinkReg][15:0] + 16'd1;
      A_EOR: begin val = a ^ b; we = 1'b1; end
      A_LSL: begin val = a << sh; we = 1'b1; end
      A_LSR: begin val = a >> sh; we = 1'b1; end
      A_MUL: begin val = a * b; we = 1'b1; end
      A_ORR: begin val = a | b; we = 1'b1; end
      A_SUB: begin val = a - b; we = 1'b1; end
      A_SUBS: begin val = a - b; shadow_flags = sub_flags(a, b); we = 1'b1; end
      A_UDIV: begin val = (b == 64'd0) ? 64'd0 : a / b; we = 1'b1; end
      A_B: nxt = shadow_pc + imm[15:0];
      A_BL: begin
        rd = LinkReg; val = {48'd0, shadow_pc}; we = 1'b1;
        nxt = shadow_pc + imm[15:0];
      end
      A_BCOND: if (cond < CondCount && shadow_flags[cond]) nxt = shadow_pc + imm[15:0];
      A_CBNZ: if (shadow_regs[rd] != 64'd0) nxt = shadow_pc + imm[15:0];
      A_CBZ: if (shadow_regs[rd] == 64'd0) nxt = shadow_pc + imm[15:0];
      A_LDUR, A_STUR: begin
        if (rn == StackBaseReg) begin
          if ($signed(addr) <= $signed(shadow_regs[FrameBoundReg])) begin
            if (act == A_LDUR) begin
              val = shadow_stack[addr[8:3]]; we = 1'b1;
            end else begin
              shadow_stack[addr[8:3]] = shadow_regs[rd];
            end
          end else begin
            fault = 1'b1;
          end
        end else if (act == A_LDUR) begin
          val = shadow_main[addr[11:3]]; we = 1'b1;
        end else begin
          shadow_main[addr[11:3]] = shadow_regs[rd];
        end
      end
      A_HALT: begin halt = 1'b1; nxt = shadow_pc; end
      default: ;
    endcase
    if (we) shadow_regs[rd] = val;
    shadow_pc = nxt;
    r.next_pc = nxt;
    r.halted = halt;
    r.write_enable = we;
    r.written_value = we ? val : 64'd0;
    r.stack_fault = fault;
    return r;
  endfunction

  // send one instruction beat after a random gap, record its expectation
  task automatic issue(logic [4:0] act, logic [4:0] rd, logic [4:0] rn,
      logic [4:0] rm, logic [25:0] imm26, logic [5:0] sh, logic [3:0] cond);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    // step off the edge where start was dropped, busy is high there anyway
    repeat (gap + 1) @(posedge clk);
    start <= 1'b1;
    in_action <= act; in_dest_reg <= rd; in_src_reg <= rn;
    in_second_reg <= rm; in_imm <= imm26; in_shift_amount <= sh;
    in_condition <= cond;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_retires.push_back(execute_instr(act, rd, rn, rm, imm26, sh, cond));
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending_retires.size() != 0) @(posedge clk);
  endtask

  // random register, biased toward the stack pair and the link register
  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 7))
      0: return StackBaseReg;
      1: return FrameBoundReg;
      2: return LinkReg;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [25:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 26'($urandom);
      1: return 26'h1FFFFFF;
      2: return 26'h2000000;
      default: return 26'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  task automatic test_alu_extremes();
    issue(A_ADDI, 5'd1, 5'd0, 5'd0, 26'h1FFFFFF, 6'd0, C_EQ);
    issue(A_SUBI, 5'd2, 5'd0, 5'd0, 26'h1FFFFFF, 6'd0, C_EQ);
    issue(A_ADDI, 5'd3, 5'd0, 5'd0, 26'h2000000, 6'd0, C_EQ);
    issue(A_ANDI, 5'd4, 5'd2, 5'd0, 26'h3FFFFFF, 6'd0, C_EQ);
    issue(A_EORI, 5'd5, 5'd1, 5'd0, 26'h2AAAAAA, 6'd0, C_EQ);
    issue(A_ORRI, 5'd6, 5'd3, 5'd0, 26'h0155555, 6'd0, C_EQ);
    issue(A_ADD, 5'd7, 5'd2, 5'd3, '0, 6'd0, C_EQ);
    issue(A_AND, 5'd8, 5'd5, 5'd6, '0, 6'd0, C_EQ);
    issue(A_EOR, 5'd9, 5'd5, 5'd6, '0, 6'd0, C_EQ);
    issue(A_ORR, 5'd10, 5'd5, 5'd6, '0, 6'd0, C_EQ);
    issue(A_SUB, 5'd11, 5'd0, 5'd2, '0, 6'd0, C_EQ);
    issue(A_LSL, 5'd12, 5'd2, 5'd0, '0, 6'd63, C_EQ);
    issue(A_LSR, 5'd13, 5'd3, 5'd0, '0, 6'd63, C_EQ);
    issue(A_MUL, 5'd14, 5'd2, 5'd3, '0, 6'd0, C_EQ);
    // udiv by zero, then a real quotient
    issue(A_UDIV, 5'd15, 5'd3, 5'd0, '0, 6'd0, C_EQ);
    issue(A_UDIV, 5'd16, 5'd3, 5'd1, '0, 6'd0, C_EQ);
    issue(A_SUBS, 5'd17, 5'd3, 5'd1, '0, 6'd0, C_EQ);
    issue(A_SUBIS, 5'd31, 5'd0, 5'd0, '0, 6'd0, C_EQ);
  endtask

  task automatic test_control_flow();
    issue(A_BL, 5'd0, 5'd0, 5'd0, 26'h2000000, 6'd0, C_EQ);
    issue(A_BR, 5'd0, 5'd7, 5'd0, '0, 6'd0, C_EQ);
    issue(A_B, 5'd0, 5'd0, 5'd0, 26'h1FFFFFF, 6'd0, C_EQ);
    // invalid condition code is never taken
    issue(A_BCOND, 5'd0, 5'd0, 5'd0, 26'd9, 6'd0, 4'd15);
    issue(A_CBZ, 5'd20, 5'd0, 5'd0, 26'd5, 6'd0, C_EQ);
    issue(A_CBNZ, 5'd2, 5'd0, 5'd0, 26'd5, 6'd0, C_EQ);
    issue(A_HALT, 5'd0, 5'd0, 5'd0, '0, 6'd0, C_EQ);
    issue(A_NOP, 5'd0, 5'd0, 5'd0, '0, 6'd0, C_EQ);
    issue(5'd31, 5'd0, 5'd0, 5'd0, '0, 6'd0, C_EQ);
  endtask

  task automatic test_memory();
    // stack frame: x28 = 0, x29 = 64
    issue(A_ADDI, StackBaseReg, 5'd0, 5'd0, 26'd0, 6'd0, C_EQ);
    issue(A_ADDI, FrameBoundReg, 5'd0, 5'd0, 26'd64, 6'd0, C_EQ);
    issue(A_STUR, 5'd2, StackBaseReg, 5'd0, 26'd64, 6'd0, C_EQ);
    issue(A_LDUR, 5'd21, StackBaseReg, 5'd0, 26'd64, 6'd0, C_EQ);
    // one past the bound faults
    issue(A_STUR, 5'd2, StackBaseReg, 5'd0, 26'd65, 6'd0, C_EQ);
    issue(A_LDUR, 5'd22, StackBaseReg, 5'd0, 26'd72, 6'd0, C_EQ);
    issue(A_STUR, 5'd3, 5'd0, 5'd0, 26'h1FFFFF8, 6'd0, C_EQ);
    issue(A_LDUR, 5'd23, 5'd0, 5'd0, 26'h1FFFFF8, 6'd0, C_EQ);
    drain();
  endtask

  task automatic test_random_program(int unsigned count);
    logic [4:0] act;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) act = 5'($urandom_range(26, 31));
      else act = 5'($urandom_range(0, 25));
      // keep divides rare, each runs the bit-serial restoring divider
      if (act == A_UDIV && $urandom_range(0, 3) != 0) act = A_ADD;
      issue(act, pick_reg(), pick_reg(), pick_reg(), pick_imm(),
            6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)));
      if (i == count / 2) drain();
    end
  endtask

  // retirement checker
  always @(posedge clk) begin
    retire_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_retires.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat pc=%h", out_next_pc);
      end else begin
        exp_r = pending_retires.pop_front();
        if (out_next_pc !== exp_r.next_pc || out_halted !== exp_r.halted ||
            out_write_enable !== exp_r.write_enable ||
            out_written_value !== exp_r.written_value ||
            out_stack_fault !== exp_r.stack_fault) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp pc=%h h=%b we=%b v=%h f=%b got pc=%h h=%b we=%b v=%h f=%b",
                     exp_r.next_pc, exp_r.halted, exp_r.write_enable,
                     exp_r.written_value, exp_r.stack_fault, out_next_pc,
                     out_halted, out_write_enable, out_written_value, out_stack_fault);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat and no result beat
  always @(posedge clk) begin
    if (out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    for (int i = 0; i < MainWords; i++) shadow_main[i] = '0;
    for (int i = 0; i < StackWords; i++) shadow_stack[i] = '0;
    shadow_pc = '0;
    shadow_flags = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu_extremes();
    test_control_flow();
    test_memory();
    test_random_program(1400);
    drain();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_retires.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lse_pkg.sv
rtl/lse_ctrl.sv
rtl/lse_dp.sv
rtl/legv8_subset_execute_unit.sv
verif/tb.sv
